// File: design/vpdt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the vertex dedup table.
package vpdt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int HALF_W      = 16;
  localparam int KEY_W       = 2 * HALF_W;
  localparam int RIDX_W      = 8;
  localparam int SLOT_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int RCMP_W      = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic rd_result;
    logic scan;
    logic out_load;
  } vpdt_cmd_t;

  typedef struct packed {
    logic op_read;
    logic scan_done;
    logic out_free;
  } vpdt_stat_t;

endpackage

// File: design/vpdt_ctrl.sv
// Controller state machine sequencing read, key scan and result hand-off.
module vpdt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpdt_pkg::vpdt_stat_t stat_i,
  output vpdt_pkg::vpdt_cmd_t  cmd_o
);
  import vpdt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_RD_CMP = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.accept   = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RD_CMP;
      end
      S_RD_CMP: begin
        cmd_o.rd_result = 1'b1;
        state_d         = S_DONE;
      end
      S_SCAN: begin
        if (stat_i.op_read) begin
          state_d = S_RD;
        end else begin
          cmd_o.scan = 1'b1;
          if (stat_i.scan_done) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/vpdt_dp.sv
// Datapath: key memory, entry count, scan pointer, compare stage and result registers.
module vpdt_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vpdt_pkg::vpdt_cmd_t             cmd_i,
  output vpdt_pkg::vpdt_stat_t            stat_o,
  input  logic                            op_i,
  input  logic                            first_i,
  input  logic [vpdt_pkg::HALF_W-1:0]     position_index_i,
  input  logic [vpdt_pkg::HALF_W-1:0]     map_index_i,
  input  logic [vpdt_pkg::RIDX_W-1:0]     read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vpdt_pkg::SLOT_W-1:0]     new_index_o,
  output logic                            hit_o,
  output logic [vpdt_pkg::STATUS_W-1:0]   status_o,
  output logic [vpdt_pkg::HALF_W-1:0]     entry_position_o,
  output logic [vpdt_pkg::HALF_W-1:0]     entry_map_o,
  output logic [vpdt_pkg::CNT_W-1:0]      unique_count_o
);
  import vpdt_pkg::*;

  logic [KEY_W-1:0]  mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] raddr;

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [RIDX_W-1:0] ridx_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  scan_idx_q;
  logic [ADDR_W-1:0] cmp_idx_q;
  logic              pend_q;

  logic [SLOT_W-1:0]   res_slot_q;
  logic                res_hit_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [HALF_W-1:0]   res_pos_q;
  logic [HALF_W-1:0]   res_map_q;

  logic                out_valid_q;

  logic cmp_hit;
  logic scan_more;
  logic full;
  logic rd_in_range;
  logic scan_issue;
  logic scan_miss;

  assign cmp_hit     = pend_q && (rdata_q == key_q);
  assign scan_more   = (scan_idx_q < count_q);
  assign full        = (count_q == CNT_W'(TABLE_DEPTH));
  assign rd_in_range = (RCMP_W'(ridx_q) < RCMP_W'(count_q));
  assign scan_issue  = cmd_i.scan && !cmp_hit && scan_more;
  assign scan_miss   = cmd_i.scan && !cmp_hit && !scan_more;

  assign stat_o.op_read   = op_q;
  assign stat_o.scan_done = cmp_hit || !scan_more;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign raddr = cmd_i.rd_issue ? ADDR_W'(ridx_q) : scan_idx_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (scan_miss && !full) begin
      mem[count_q[ADDR_W-1:0]] <= key_q;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      key_q  <= {map_index_i, position_index_i};
      ridx_q <= read_index_i;
    end
    if (scan_issue) begin
      cmp_idx_q <= scan_idx_q[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_idx_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= scan_issue;
      if (cmd_i.accept) begin
        scan_idx_q <= '0;
        if ((op_i == OP_ADD) && first_i) begin
          count_q <= '0;
        end
      end else if (scan_issue) begin
        scan_idx_q <= scan_idx_q + CNT_W'(1);
      end
      if (scan_miss && !full) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_result) begin
      res_slot_q   <= '0;
      res_hit_q    <= 1'b0;
      res_status_q <= rd_in_range ? ST_OK : ST_RANGE;
      res_pos_q    <= rd_in_range ? rdata_q[HALF_W-1:0] : '0;
      res_map_q    <= rd_in_range ? rdata_q[KEY_W-1:HALF_W] : '0;
    end else if (cmd_i.scan && cmp_hit) begin
      res_slot_q   <= SLOT_W'(cmp_idx_q);
      res_hit_q    <= 1'b1;
      res_status_q <= ST_OK;
      res_pos_q    <= '0;
      res_map_q    <= '0;
    end else if (scan_miss) begin
      res_slot_q   <= full ? '0 : SLOT_W'(count_q);
      res_hit_q    <= 1'b0;
      res_status_q <= full ? ST_FULL : ST_OK;
      res_pos_q    <= '0;
      res_map_q    <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      new_index_o      <= res_slot_q;
      hit_o            <= res_hit_q;
      status_o         <= res_status_q;
      entry_position_o <= res_pos_q;
      entry_map_o      <= res_map_q;
      unique_count_o   <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/vertex_pair_dedup_table_top.sv
// Vertex pair deduplication table: controller and datapath.
//
// Input channel (in_valid_i/in_ready_o) carries one transaction per item: an add
// (op 0) packs map_index:position_index into a 32-bit key and searches the stored
// unique keys from slot 0; a hit returns the earlier slot, a miss appends the key
// (or reports full). first_i empties the table before an add. A read (op 1)
// returns both halves of one stored key, or status 2 beyond the count.
// Output channel (out_valid_o/out_ready_i) returns exactly one transaction per item.
// A read passes through the states RD and RD_CMP before the output load. An add
// compares one stored key per cycle through the single read port of the key
// memory, up to all 256 keys of a full table.
// One item is in work at a time; the next item is taken once the result is in
// the output register, even while that result still waits for the receiver.
// Reset clears the entry count and all handshake state; the key memory is not
// cleared and its contents are only used below the count. A stalled receiver holds the output
// register and, after one finished item, holds off further input.
module vertex_pair_dedup_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic                            first_i,
  input  logic [vpdt_pkg::HALF_W-1:0]     position_index_i,
  input  logic [vpdt_pkg::HALF_W-1:0]     map_index_i,
  input  logic [vpdt_pkg::RIDX_W-1:0]     read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vpdt_pkg::SLOT_W-1:0]     new_index_o,
  output logic                            hit_o,
  output logic [vpdt_pkg::STATUS_W-1:0]   status_o,
  output logic [vpdt_pkg::HALF_W-1:0]     entry_position_o,
  output logic [vpdt_pkg::HALF_W-1:0]     entry_map_o,
  output logic [vpdt_pkg::CNT_W-1:0]      unique_count_o
);
  import vpdt_pkg::*;

  vpdt_cmd_t  cmd;
  vpdt_stat_t stat;

  vpdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vpdt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (op_i),
    .first_i          (first_i),
    .position_index_i (position_index_i),
    .map_index_i      (map_index_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .new_index_o      (new_index_o),
    .hit_o            (hit_o),
    .status_o         (status_o),
    .entry_position_o (entry_position_o),
    .entry_map_o      (entry_map_o),
    .unique_count_o   (unique_count_o)
  );

endmodule
